// ----- design/m3i_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// m3i_pkg
// Shared constants and helpers for the 3x3 matrix inverse pipeline.
// ---------------------------------------------------------------------------
package m3i_pkg;

   localparam int DIM    = 3;
   localparam int N_ELEM = DIM * DIM;

   // Cyclic row or column index, (i + k) mod 3.
   function automatic int cyc(input int i, input int k);
      return (i + k) % DIM;
   endfunction

   // Width of a divider remainder: holds the scaled numerator plus the
   // determinant magnitude, and the doubled divisor shifted by the quotient width.
   function automatic int rem_width(input int w, input int f);
      return (2 * w + 2 * f + 2 > 4 * w + 1) ? 2 * w + 2 * f + 2 : 4 * w + 1;
   endfunction

endpackage

// ----- design/m3i_cof.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// m3i_cof
// Four-stage front end: 2x2 products, cofactors, partial products of the
// first-row expansion, and the exact determinant.
// ---------------------------------------------------------------------------
module m3i_cof #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic signed [DATA_WIDTH-1:0]   elem [m3i_pkg::N_ELEM],
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic signed [2*DATA_WIDTH:0]   cof  [m3i_pkg::N_ELEM],
   output logic signed [3*DATA_WIDTH+2:0] det
);
   import m3i_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int CW = 2 * W + 1;
   localparam int DW = 3 * W + 3;
   localparam int NS = 4;

   logic [NS-1:0] vld_ff;
   logic [NS:0]   rdy;

   logic signed [2*W-1:0] pa_in [N_ELEM], pa_ff [N_ELEM];
   logic signed [2*W-1:0] pb_in [N_ELEM], pb_ff [N_ELEM];
   logic signed [W-1:0]   row_a_ff [DIM], row_b_ff [DIM];
   logic signed [CW-1:0]  cof_b_in [N_ELEM], cof_b_ff [N_ELEM];
   logic signed [CW-1:0]  cof_c_ff [N_ELEM], cof_d_ff [N_ELEM];
   logic signed [CW-1:0]  pl_in [DIM], pl_ff [DIM];
   logic signed [CW-1:0]  ph_in [DIM], ph_ff [DIM];
   logic signed [DW-1:0]  det_in, det_ff;

   assign rdy[NS] = out_ready;
   genvar g;
   generate
      for (g = 0; g < NS; g++) begin : g_rdy
         assign rdy[g] = !vld_ff[g] || rdy[g+1];
      end
   endgenerate

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[NS-1];
   assign cof       = cof_d_ff;
   assign det       = det_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) vld_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) begin
            if (rdy[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // Stage A: the two products of every cyclic cofactor.
   always_comb begin
      int r1, r2, c1, c2, idx;
      for (int r = 0; r < DIM; r++) begin
         for (int c = 0; c < DIM; c++) begin
            r1  = cyc(r, 1);
            r2  = cyc(r, 2);
            c1  = cyc(c, 1);
            c2  = cyc(c, 2);
            idx = r * DIM + c;
            pa_in[idx] = elem[r1*DIM+c1] * elem[r2*DIM+c2];
            pb_in[idx] = elem[r2*DIM+c1] * elem[r1*DIM+c2];
         end
      end
   end

   // Stage B: cofactors; stage C: first-row terms split into low and high halves.
   always_comb begin
      for (int i = 0; i < N_ELEM; i++) begin
         cof_b_in[i] = CW'(pa_ff[i]) - CW'(pb_ff[i]);
      end
      for (int c = 0; c < DIM; c++) begin
         pl_in[c] = row_b_ff[c] * $signed({1'b0, cof_b_ff[c][W-1:0]});
         ph_in[c] = row_b_ff[c] * $signed(cof_b_ff[c][CW-1:W]);
      end
   end

   // Stage D: recombine the halves and sum the three terms.
   always_comb begin
      det_in = '0;
      for (int c = 0; c < DIM; c++) begin
         det_in = det_in + (DW'(ph_ff[c]) <<< W) + DW'(pl_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         for (int c = 0; c < DIM; c++) row_a_ff[c] <= elem[c];
      end
      if (rdy[1]) begin
         cof_b_ff <= cof_b_in;
         row_b_ff <= row_a_ff;
      end
      if (rdy[2]) begin
         cof_c_ff <= cof_b_ff;
         pl_ff    <= pl_in;
         ph_ff    <= ph_in;
      end
      if (rdy[3]) begin
         cof_d_ff <= cof_c_ff;
         det_ff   <= det_in;
      end
   end

endmodule

// ----- design/m3i_prep.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// m3i_prep
// Divider set-up: magnitudes, result signs, rounded dividends, overflow
// check, and the rounded and saturated determinant output.
// ---------------------------------------------------------------------------
module m3i_prep #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic signed [2*DATA_WIDTH:0]   cof  [m3i_pkg::N_ELEM],
   input  logic signed [3*DATA_WIDTH+2:0] det,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [m3i_pkg::rem_width(DATA_WIDTH, FRAC_BITS)-1:0] rem [m3i_pkg::N_ELEM],
   output logic [m3i_pkg::N_ELEM-1:0]     neg,
   output logic [m3i_pkg::N_ELEM-1:0]     ovf,
   output logic [3*DATA_WIDTH:0]          dvs,
   output logic [DATA_WIDTH-1:0]          det_value,
   output logic                           singular
);
   import m3i_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int CW = 2 * W + 1;
   localparam int DW = 3 * W + 3;
   localparam int RW = rem_width(W, F);
   localparam logic [3*W:0] DHALF = {{(3*W){1'b0}}, 1'b1} << (2 * F - 1);
   localparam logic [3*W:0] POS_LIM = (3*W+1)'({1'b0, {(W-1){1'b1}}});

   logic              vld_ff;
   logic [RW-1:0]     rem_in [N_ELEM], rem_ff [N_ELEM];
   logic [N_ELEM-1:0] neg_in, neg_ff, ovf_in, ovf_ff;
   logic [3*W:0]      dvs_in, dvs_ff;
   logic [W-1:0]      detv_in, detv_ff;
   logic              sing_in, sing_ff;

   assign in_ready  = !vld_ff || out_ready;
   assign out_valid = vld_ff;
   assign rem       = rem_ff;
   assign neg       = neg_ff;
   assign ovf       = ovf_ff;
   assign dvs       = dvs_ff;
   assign det_value = detv_ff;
   assign singular  = sing_ff;

   always_comb begin
      logic [DW-1:0]  dfull;
      logic [3*W-1:0] dmag;
      logic [CW-1:0]  nfull;
      logic [CW-1:0]  num;
      logic [3*W:0]   dsum, dq, dlim, dm;
      logic           dneg;

      dneg    = det[DW-1];
      dfull   = dneg ? (~det + 1'b1) : det;
      dmag    = dfull[3*W-1:0];
      dvs_in  = {dmag, 1'b0};
      sing_in = (det == '0);

      // The inverse is the transposed cofactor matrix over the determinant.
      for (int r = 0; r < DIM; r++) begin
         for (int c = 0; c < DIM; c++) begin
            num   = cof[c*DIM+r];
            nfull = num[CW-1] ? (~num + 1'b1) : num;
            rem_in[r*DIM+c] = (RW'(nfull[2*W-1:0]) << (2 * F + 1)) + RW'(dmag);
            neg_in[r*DIM+c] = num[CW-1] ^ dneg;
            ovf_in[r*DIM+c] = rem_in[r*DIM+c] >= (RW'(dvs_in) << W);
         end
      end

      // Determinant output: divide by 2^(2F) with round half away from zero.
      dsum    = (3*W+1)'(dmag) + DHALF;
      dq      = dsum >> (2 * F);
      dlim    = POS_LIM + (3*W+1)'(dneg);
      dm      = (dq > dlim) ? dlim : dq;
      detv_in = dneg ? (~dm[W-1:0] + 1'b1) : dm[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         rem_ff  <= rem_in;
         neg_ff  <= neg_in;
         ovf_ff  <= ovf_in;
         dvs_ff  <= dvs_in;
         detv_ff <= detv_in;
         sing_ff <= sing_in;
      end
   end

endmodule

// ----- design/m3i_div.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// m3i_div
// Pipelined restoring divider, nine lanes sharing one divisor. Each stage
// resolves one quotient bit, most significant first.
// ---------------------------------------------------------------------------
module m3i_div #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [m3i_pkg::rem_width(DATA_WIDTH, FRAC_BITS)-1:0] rem [m3i_pkg::N_ELEM],
   input  logic [m3i_pkg::N_ELEM-1:0] neg,
   input  logic [m3i_pkg::N_ELEM-1:0] ovf,
   input  logic [3*DATA_WIDTH:0]      dvs,
   input  logic [DATA_WIDTH-1:0]      det_value,
   input  logic                       singular,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [DATA_WIDTH-1:0]      quo [m3i_pkg::N_ELEM],
   output logic [m3i_pkg::N_ELEM-1:0] neg_out,
   output logic [m3i_pkg::N_ELEM-1:0] ovf_out,
   output logic [DATA_WIDTH-1:0]      det_out,
   output logic                       sing_out
);
   import m3i_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int RW = rem_width(DATA_WIDTH, FRAC_BITS);

   logic [W-1:0]      vld_ff;
   logic [W:0]        rdy;
   logic [RW-1:0]     rem_src [W][N_ELEM];
   logic [RW-1:0]     rem_ff  [W][N_ELEM];
   logic [RW-1:0]     rem_in  [W][N_ELEM];
   logic [W-1:0]      quo_src [W][N_ELEM];
   logic [W-1:0]      quo_ff  [W][N_ELEM];
   logic [W-1:0]      quo_in  [W][N_ELEM];
   logic [N_ELEM-1:0] neg_src [W], neg_ff [W];
   logic [N_ELEM-1:0] ovf_src [W], ovf_ff [W];
   logic [3*W:0]      dvs_src [W], dvs_ff [W];
   logic [W-1:0]      detv_src [W], detv_ff [W];
   logic [W-1:0]      sing_src, sing_ff;

   assign rdy[W]    = out_ready;
   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[W-1];
   assign quo       = quo_ff[W-1];
   assign neg_out   = neg_ff[W-1];
   assign ovf_out   = ovf_ff[W-1];
   assign det_out   = detv_ff[W-1];
   assign sing_out  = sing_ff[W-1];

   genvar k;
   generate
      for (k = 0; k < W; k++) begin : g_stage
         assign rdy[k] = !vld_ff[k] || rdy[k+1];

         if (k == 0) begin : g_first
            assign rem_src[k]  = rem;
            assign neg_src[k]  = neg;
            assign ovf_src[k]  = ovf;
            assign dvs_src[k]  = dvs;
            assign detv_src[k] = det_value;
            assign sing_src[k] = singular;
            for (genvar j = 0; j < N_ELEM; j++) begin : g_q0
               assign quo_src[k][j] = '0;
            end
         end else begin : g_next
            assign rem_src[k]  = rem_ff[k-1];
            assign quo_src[k]  = quo_ff[k-1];
            assign neg_src[k]  = neg_ff[k-1];
            assign ovf_src[k]  = ovf_ff[k-1];
            assign dvs_src[k]  = dvs_ff[k-1];
            assign detv_src[k] = detv_ff[k-1];
            assign sing_src[k] = sing_ff[k-1];
         end

         // Trial subtract of the divisor aligned to quotient bit W-1-k.
         always_comb begin
            logic [RW-1:0] sh;
            logic          ge;
            sh = RW'(dvs_src[k]) << (W - 1 - k);
            for (int j = 0; j < N_ELEM; j++) begin
               ge           = rem_src[k][j] >= sh;
               rem_in[k][j] = ge ? rem_src[k][j] - sh : rem_src[k][j];
               quo_in[k][j] = quo_src[k][j] | (W'(ge) << (W - 1 - k));
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else if (rdy[k]) begin
               vld_ff[k] <= (k == 0) ? in_valid : vld_ff[(k == 0) ? 0 : k - 1];
            end
         end

         always_ff @(posedge clock) begin
            if (rdy[k]) begin
               rem_ff[k]  <= rem_in[k];
               quo_ff[k]  <= quo_in[k];
               neg_ff[k]  <= neg_src[k];
               ovf_ff[k]  <= ovf_src[k];
               dvs_ff[k]  <= dvs_src[k];
               detv_ff[k] <= detv_src[k];
               sing_ff[k] <= sing_src[k];
            end
         end
      end
   endgenerate

endmodule

// ----- design/m3i_out.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// m3i_out
// Output stage: saturation, sign restore, singular zeroing, result register.
// ---------------------------------------------------------------------------
module m3i_out #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [DATA_WIDTH-1:0]      quo [m3i_pkg::N_ELEM],
   input  logic [m3i_pkg::N_ELEM-1:0] neg,
   input  logic [m3i_pkg::N_ELEM-1:0] ovf,
   input  logic [DATA_WIDTH-1:0]      det_value,
   input  logic                       singular,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [DATA_WIDTH-1:0]      inv [m3i_pkg::N_ELEM],
   output logic [DATA_WIDTH-1:0]      det_out,
   output logic                       sing_out
);
   import m3i_pkg::*;

   localparam int W = DATA_WIDTH;
   localparam logic [W-1:0] POS_LIM = {1'b0, {(W-1){1'b1}}};

   logic         vld_ff;
   logic [W-1:0] inv_in [N_ELEM], inv_ff [N_ELEM];
   logic [W-1:0] det_in, det_ff;
   logic         sing_ff;

   assign in_ready  = !vld_ff || out_ready;
   assign out_valid = vld_ff;
   assign inv       = inv_ff;
   assign det_out   = det_ff;
   assign sing_out  = sing_ff;

   always_comb begin
      logic [W-1:0] lim, mag;
      for (int j = 0; j < N_ELEM; j++) begin
         // A negative result may reach one step further than a positive one.
         lim = POS_LIM + W'(neg[j]);
         mag = (ovf[j] || quo[j] > lim) ? lim : quo[j];
         if (singular) begin
            inv_in[j] = '0;
         end else begin
            inv_in[j] = neg[j] ? (~mag + 1'b1) : mag;
         end
      end
      det_in = singular ? '0 : det_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         inv_ff  <= inv_in;
         det_ff  <= det_in;
         sing_ff <= singular;
      end
   end

endmodule

// ----- design/matrix3x3_inverse.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// matrix3x3_inverse
// Fixed-point 3x3 matrix inverse by adjugate and exact determinant.
// ---------------------------------------------------------------------------
// One matrix is accepted per clock unless a stall holds the input; its result
// passes four stages that build the cofactors and the exact determinant, one
// stage that sets up the division, a DATA_WIDTH-stage restoring divider that
// resolves one quotient bit per stage in nine lanes at once, and a last stage
// that saturates, restores signs and holds the result word. Every stage that
// holds no word keeps taking new words while the output is stalled.
// Results round half away from zero and saturate; a matrix with an exact zero
// determinant gives singular = 1 with all outputs zero.
// ---------------------------------------------------------------------------
module matrix3x3_inverse #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic clock,
   input  logic reset,
   // m00, m01, m02, m10, m11, m12, m20, m21, m22 from the lowest bit up
   input  logic [((9*DATA_WIDTH+7)/8)*8-1:0]  req_tdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22,
   // det_value from the lowest bit up
   output logic [((10*DATA_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // singular
   output logic [0:0]                         rsp_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready
);
   import m3i_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int CW = 2 * W + 1;
   localparam int DW = 3 * W + 3;
   localparam int RW = rem_width(DATA_WIDTH, FRAC_BITS);

   logic signed [W-1:0]  elem [N_ELEM];
   logic signed [CW-1:0] cof  [N_ELEM];
   logic signed [DW-1:0] det;
   logic                 cof_valid, cof_ready;

   logic [RW-1:0]     p_rem [N_ELEM];
   logic [N_ELEM-1:0] p_neg, p_ovf;
   logic [3*W:0]      p_dvs;
   logic [W-1:0]      p_detv;
   logic              p_sing, p_valid, p_ready;

   logic [W-1:0]      d_quo [N_ELEM];
   logic [N_ELEM-1:0] d_neg, d_ovf;
   logic [W-1:0]      d_detv;
   logic              d_sing, d_valid, d_ready;

   logic [W-1:0]      inv [N_ELEM];
   logic [W-1:0]      det_value;
   logic              singular;

   always_comb begin
      for (int j = 0; j < N_ELEM; j++) begin
         elem[j] = req_tdata[j*W +: W];
      end
   end

   always_comb begin
      rsp_tdata = '0;
      for (int j = 0; j < N_ELEM; j++) begin
         rsp_tdata[j*W +: W] = inv[j];
      end
      rsp_tdata[N_ELEM*W +: W] = det_value;
      rsp_tuser[0] = singular;
   end

   m3i_cof #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_cof (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .elem      (elem),
      .out_valid (cof_valid),
      .out_ready (cof_ready),
      .cof       (cof),
      .det       (det)
   );

   m3i_prep #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cof_valid),
      .in_ready  (cof_ready),
      .cof       (cof),
      .det       (det),
      .out_valid (p_valid),
      .out_ready (p_ready),
      .rem       (p_rem),
      .neg       (p_neg),
      .ovf       (p_ovf),
      .dvs       (p_dvs),
      .det_value (p_detv),
      .singular  (p_sing)
   );

   m3i_div #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p_valid),
      .in_ready  (p_ready),
      .rem       (p_rem),
      .neg       (p_neg),
      .ovf       (p_ovf),
      .dvs       (p_dvs),
      .det_value (p_detv),
      .singular  (p_sing),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .quo       (d_quo),
      .neg_out   (d_neg),
      .ovf_out   (d_ovf),
      .det_out   (d_detv),
      .sing_out  (d_sing)
   );

   m3i_out #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid),
      .in_ready  (d_ready),
      .quo       (d_quo),
      .neg       (d_neg),
      .ovf       (d_ovf),
      .det_value (d_detv),
      .singular  (d_sing),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .inv       (inv),
      .det_out   (det_value),
      .sing_out  (singular)
   );

endmodule

// ----- design/m3i_check.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// m3i_check
// Port-level checks for the 3x3 matrix inverse, bound to the top level.
// ---------------------------------------------------------------------------
module m3i_check #(
   parameter int DATA_WIDTH = 32
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tready,
   input logic [((10*DATA_WIDTH+7)/8)*8-1:0] rsp_tdata,
   input logic [0:0]                         rsp_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready
);

   // A singular matrix returns an all-zero inverse and determinant.
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[10*DATA_WIDTH-1:0] == '0)
      else $error("singular word carries nonzero data");

   // A stalled result word holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser))
      else $error("stalled result word changed");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word valid right after reset");

   // With an empty output register the block can always take a word.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && $past(!rsp_tvalid) && !$past(reset) |-> req_tready)
      else $error("input stalled while output side is free");

endmodule

bind matrix3x3_inverse m3i_check #(
   .DATA_WIDTH (DATA_WIDTH)
) u_m3i_check (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

// ----- test/m3i_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// m3i_checker
// Watches both channels of the matrix inverse and checks every result word.
// ---------------------------------------------------------------------------
// Each accepted matrix is inverted here with exact wide arithmetic; the
// expected inverse, determinant and singular flag are queued and compared in
// order with the words that leave the block.
// ---------------------------------------------------------------------------
module m3i_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic [287:0] req_tdata,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [319:0] rsp_tdata,
   input  logic [0:0]   rsp_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   output int           fail_count,
   output int           pending_count
);
   import m3i_pkg::*;

   typedef struct {
      logic [319:0] data;
      logic         singular;
   } inverse_word_type;

   inverse_word_type inverse_q[$];

   // Rounds num / den half away from zero and clamps it to 32 signed bits.
   function automatic logic [31:0] round_div_sat(input logic signed [199:0] num,
                                                 input logic signed [199:0] den);
      logic         neg;
      logic [199:0] n, d, q;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      q = (2 * n + d) / (2 * d);
      if (neg) begin
         if (q > 200'h80000000) q = 200'h80000000;
         return -q[31:0];
      end
      if (q > 200'h7FFFFFFF) q = 200'h7FFFFFFF;
      return q[31:0];
   endfunction

   function automatic inverse_word_type invert_matrix(input logic [287:0] word);
      logic signed [199:0] el [3][3];
      logic signed [199:0] cof [3][3];
      logic signed [199:0] det;
      inverse_word_type res;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            el[r][c] = 200'(signed'(word[(r*3+c)*32 +: 32]));
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            cof[r][c] = el[cyc(r,1)][cyc(c,1)] * el[cyc(r,2)][cyc(c,2)]
                      - el[cyc(r,2)][cyc(c,1)] * el[cyc(r,1)][cyc(c,2)];
      det = el[0][0]*cof[0][0] + el[0][1]*cof[0][1] + el[0][2]*cof[0][2];
      res.data = '0;
      res.singular = (det == 0);
      if (!res.singular) begin
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
               res.data[(r*3+c)*32 +: 32] = round_div_sat(cof[c][r] <<< 32, det);
         res.data[9*32 +: 32] = round_div_sat(det, 200'sd1 <<< 32);
      end
      return res;
   endfunction

   assign pending_count = inverse_q.size();

   always @(posedge clock) begin
      inverse_word_type want;
      int errs;
      errs = 0;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready) inverse_q.push_back(invert_matrix(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (inverse_q.size() == 0) begin
               $display("%0t: unexpected result word %h", $time, rsp_tdata);
               errs++;
            end else begin
               want = inverse_q.pop_front();
               for (int f = 0; f < 10; f++)
                  if (rsp_tdata[f*32 +: 32] !== want.data[f*32 +: 32]) begin
                     $display("%0t: field %0d expected %h actual %h", $time, f,
                              want.data[f*32 +: 32], rsp_tdata[f*32 +: 32]);
                     errs++;
                  end
               if (rsp_tuser[0] !== want.singular) begin
                  $display("%0t: singular expected %b actual %b", $time,
                           want.singular, rsp_tuser[0]);
                  errs++;
               end
            end
         end
         if (errs != 0) fail_count <= fail_count + errs;
      end
   end
endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the 3x3 matrix inverse.
// ---------------------------------------------------------------------------
// Sends directed matrices (extremes, identity, singular, tiny and huge
// determinants) and then random ones of varied magnitude, with random gaps
// and output stalls; the checker module predicts and compares.
// ---------------------------------------------------------------------------
module tb_top;
   logic         clock;
   logic         reset;
   logic [287:0] req_tdata;
   logic         req_tvalid;
   logic         req_tready;
   logic [319:0] rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   int           fail_count;
   int           pending_count;
   logic         long_hold;

   localparam logic [31:0] ONE = 32'h0001_0000;

   matrix3x3_inverse dut (.*);

   m3i_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // One element of a random matrix, mostly near unit scale.
   function automatic logic [31:0] rand_elem();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2: return 32'($signed($urandom_range(0, 8)) - 4);
         default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      endcase
   endfunction

   // The valid line stays high across back-to-back words and drops only
   // for a gap.
   task automatic send_matrix(input logic [287:0] word);
      int gap;
      gap = $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_elems(input logic [31:0] a, b, c, d, e, f, g, h, i);
      send_matrix({i, h, g, f, e, d, c, b, a});
   endtask

   // Receiver: random stalls, plus one long hold-off when requested.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            long_hold = 1'b0;
         end
         stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin
      logic [287:0] w;
      int wait_cycles;
      long_hold  = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_elems(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
      send_elems(ONE<<1, 0, 0, 0, ONE<<2, 0, 0, 0, -ONE);
      send_elems(0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_elems(ONE, ONE, ONE, ONE, ONE, ONE, 1, 2, 3);
      send_elems(1, 0, 0, 0, 1, 0, 0, 0, 1);
      send_elems(32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF);
      send_elems(32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 32'h8000_0000);
      send_elems(32'h8000_0000, 32'h7FFF_FFFF, 1, 2, 32'h8000_0000, 3, 5, 7,
                 32'h7FFF_FFFF);
      send_elems(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFD);
      send_elems(ONE<<1, ONE, 0, ONE, ONE<<1, ONE, 0, ONE, ONE<<1);
      send_elems(3, 0, 0, 0, ONE, 0, 0, 0, ONE);
      send_elems(0, ONE, 0, 0, 0, ONE, ONE, 0, 0);

      // Stall the output so the pipeline fills while input keeps coming.
      long_hold = 1'b1;
      for (int k = 0; k < 600; k++) begin
         for (int e = 0; e < 9; e++) w[e*32 +: 32] = rand_elem();
         // Some singular matrices: duplicate a row.
         if ($urandom_range(0, 9) == 0) w[96 +: 96] = w[0 +: 96];
         send_matrix(w);
         if (k == 300) begin
            // Pause until every queued result is back.
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      wait_cycles = 0;
      while (pending_count != 0 && wait_cycles < 100_000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (60) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

// ----- matrix3x3_inverse.f -----
design/m3i_pkg.sv
design/m3i_cof.sv
design/m3i_prep.sv
design/m3i_div.sv
design/m3i_out.sv
design/matrix3x3_inverse.sv
design/m3i_check.sv
test/m3i_checker.sv
test/tb_top.sv
